// ===== hw/rtl/mdfr_pkg.sv =====
// Shared types, codes and CRC helper for the distance frame receiver.
package mdfr_pkg;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } mdfr_in_t;

  typedef struct packed {
    logic [15:0] distance;
    logic [1:0]  status;
  } mdfr_out_t;

  typedef struct packed {
    logic      valid;
    mdfr_out_t data;
  } mdfr_result_t;

  // Item kinds
  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // Result status codes
  localparam logic [1:0] STATUS_ACCEPT  = 2'd0;
  localparam logic [1:0] STATUS_REJECT  = 2'd1;
  localparam logic [1:0] STATUS_TIMEOUT = 2'd2;

  // Config register indexes
  localparam logic REG_TIMEOUT_TICKS = 1'b0;
  localparam logic REG_MAX_DISTANCE  = 1'b1;

  localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd100;
  localparam logic [15:0] MAX_DISTANCE_RESET  = 16'd4000;

  // Frame bytes
  localparam logic [7:0] ADDR_BYTE  = 8'h01;
  localparam logic [7:0] HUNT_BYTE  = 8'h03;
  localparam logic [7:0] COUNT_BYTE = 8'h02;

  // Byte positions after the function code
  localparam logic [2:0] POS_COUNT     = 3'd0;
  localparam logic [2:0] POS_DIST_HIGH = 3'd1;
  localparam logic [2:0] POS_DIST_LOW  = 3'd2;
  localparam logic [2:0] POS_CRC_LOW   = 3'd3;
  localparam logic [2:0] POS_CRC_HIGH  = 3'd4;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // One byte through the reflected CRC-16, eight shift steps
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // CRC after the fixed header 01 03 02
  localparam logic [15:0] CRC_PREFIX =
    crc_feed(crc_feed(crc_feed(CRC_INIT, ADDR_BYTE), HUNT_BYTE), COUNT_BYTE);

endpackage

// ===== hw/rtl/mdfr_parser.sv =====
// Frame parser state, running CRC and result decision for one item per cycle while go is high.
module mdfr_parser import mdfr_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         go,
  input  mdfr_in_t     item,
  input  logic [15:0]  timeout_ticks,
  input  logic [15:0]  max_distance,
  output mdfr_result_t result
);

  logic        synced, synced_next;
  logic [2:0]  byte_position, byte_position_next;
  logic [7:0]  distance_high, distance_high_next;
  logic [7:0]  distance_low, distance_low_next;
  logic [7:0]  crc_low_byte, crc_low_byte_next;
  logic [15:0] last_good_distance, last_good_distance_next;
  logic [15:0] tick_count, tick_count_next;
  logic [15:0] crc, crc_next;

  logic [15:0] tick_inc;
  logic [15:0] frame_distance;
  logic [15:0] rx_crc;

  assign tick_inc       = tick_count + 16'd1;
  assign frame_distance = {distance_high, distance_low};
  assign rx_crc         = {item.rx_byte, crc_low_byte};

  always_comb begin
    synced_next             = synced;
    byte_position_next      = byte_position;
    distance_high_next      = distance_high;
    distance_low_next       = distance_low;
    crc_low_byte_next       = crc_low_byte;
    last_good_distance_next = last_good_distance;
    tick_count_next         = tick_count;
    crc_next                = crc;
    result.valid            = 1'b0;
    result.data.distance    = last_good_distance;
    result.data.status      = STATUS_REJECT;

    if (item.mode == MODE_TICK) begin
      tick_count_next = tick_inc;
      if (tick_inc >= timeout_ticks) begin
        result.valid       = 1'b1;
        result.data.status = STATUS_TIMEOUT;
        synced_next        = 1'b0;
        byte_position_next = POS_COUNT;
        tick_count_next    = 16'd0;
      end
    end else if (!synced) begin
      if (item.rx_byte == HUNT_BYTE) begin
        synced_next        = 1'b1;
        byte_position_next = POS_COUNT;
      end
    end else begin
      case (byte_position)
        POS_COUNT: begin
          if (item.rx_byte != COUNT_BYTE) begin
            synced_next        = 1'b0;
            byte_position_next = POS_COUNT;
          end else begin
            byte_position_next = POS_DIST_HIGH;
          end
        end
        POS_DIST_HIGH: begin
          distance_high_next = item.rx_byte;
          crc_next           = crc_feed(CRC_PREFIX, item.rx_byte);
          byte_position_next = POS_DIST_LOW;
        end
        POS_DIST_LOW: begin
          distance_low_next  = item.rx_byte;
          crc_next           = crc_feed(crc, item.rx_byte);
          byte_position_next = POS_CRC_LOW;
        end
        POS_CRC_LOW: begin
          crc_low_byte_next  = item.rx_byte;
          byte_position_next = POS_CRC_HIGH;
        end
        default: begin
          // CRC high byte closes the frame
          result.valid = 1'b1;
          if (frame_distance <= max_distance && crc == rx_crc) begin
            last_good_distance_next = frame_distance;
            result.data.distance    = frame_distance;
            result.data.status      = STATUS_ACCEPT;
          end
          synced_next        = 1'b0;
          byte_position_next = POS_COUNT;
          tick_count_next    = 16'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      synced             <= 1'b0;
      byte_position      <= POS_COUNT;
      distance_high      <= 8'd0;
      distance_low       <= 8'd0;
      crc_low_byte       <= 8'd0;
      last_good_distance <= 16'd0;
      tick_count         <= 16'd0;
    end else if (go) begin
      synced             <= synced_next;
      byte_position      <= byte_position_next;
      distance_high      <= distance_high_next;
      distance_low       <= distance_low_next;
      crc_low_byte       <= crc_low_byte_next;
      last_good_distance <= last_good_distance_next;
      tick_count         <= tick_count_next;
    end
  end

  // Running CRC is payload; only meaningful once the distance bytes are in
  always_ff @(posedge clk) begin
    if (go) begin
      crc <= crc_next;
    end
  end

endmodule

// ===== hw/rtl/modbus_distance_frame_receiver.sv =====
// Top level: input register, frame parser, result register and config registers.
// Path: an accepted request goes through the input register and the parser into the
//   result register, where its result can be taken (input reg, result reg).
// Throughput: one request per cycle unless stalled; the parser settles each byte or tick
//   in a single pass with the CRC advanced one byte (eight shift steps) per cycle.
// Stall: the input register holds only while the result register is full and stalled.
// Reset (rst, synchronous, active high): parser cleared, last good distance 0,
//   timeout_ticks 100, max_distance 4000, both pipeline registers empty.
module modbus_distance_frame_receiver import mdfr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  mdfr_in_t    in_data,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output mdfr_out_t   out_data,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic         in_reg_valid;
  mdfr_in_t     in_reg;
  logic         out_full_stalled;
  logic         advance;
  mdfr_result_t result;
  logic [15:0]  timeout_ticks;
  logic [15:0]  max_distance;

  // The result register blocks the pipe only when it holds a request's
  // result and the far side is stalling.
  assign out_full_stalled = out_valid && out_stall;
  assign advance          = in_reg_valid && !out_full_stalled;
  assign in_stall         = in_reg_valid && out_full_stalled;

  // Config is always writable; the sender must write only while the block is idle, which the block does not enforce.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_TICKS_RESET;
      max_distance  <= MAX_DISTANCE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TIMEOUT_TICKS: timeout_ticks <= cfg_data;
        REG_MAX_DISTANCE:  max_distance  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register: loads whenever it is not held
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!in_stall) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_reg <= in_data;
    end
  end

  mdfr_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .go            (advance),
    .item          (in_reg),
    .timeout_ticks (timeout_ticks),
    .max_distance  (max_distance),
    .result        (result)
  );

  // Result register: refills when empty or drained this cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_full_stalled) begin
      out_valid <= advance && result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_full_stalled) begin
      out_data <= result.data;
    end
  end

endmodule

// ===== hw/rtl/mdfr_checker.sv =====
// Port-level checks for the distance frame receiver, bound to the top level.
module mdfr_checker import mdfr_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input mdfr_in_t    in_data,
  input logic        out_valid,
  input logic        out_stall,
  input mdfr_out_t   out_data
);

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A stalled request is held by the sender
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("request changed while stalled");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // Only defined status codes leave the block
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.status == STATUS_ACCEPT || out_data.status == STATUS_REJECT ||
                   out_data.status == STATUS_TIMEOUT))
    else $error("undefined status code");

  // Request side only stalls while the result side is full and stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("request stalled without a blocked result");

endmodule

bind modbus_distance_frame_receiver mdfr_checker u_mdfr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the Modbus distance frame receiver.
`timescale 1ns / 1ps

module testbench;
  import mdfr_pkg::*;

  // Run-away guard: the slowest legal run is roughly 830 requests, each with the
  // longest send gap and result stall on top of the pipeline.
  localparam int CYCLE_LIMIT = 1_000_000;
  // Pipeline depth is 2 (input reg, result reg); SETTLE_CYCLES covers it with margin.
  localparam int SETTLE_CYCLES = 5;
  localparam int REQS_PER_PHASE = 100;
  localparam int NUM_PHASES = 8;

  // Directed table: what each row sends, and how its result is judged.
  typedef enum logic [2:0] {
    ROW_TICK, ROW_BYTE, ROW_CRC_LO, ROW_CRC_HI, ROW_CRC_HI_BAD,
    ROW_SET_TIMEOUT, ROW_SET_MAX
  } row_kind_e;

  // CHK_MODEL: predictor decides; CHK_NONE: no reading; CHK_GIVEN: typed below.
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_GIVEN} row_chk_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [15:0] arg;
    row_chk_e    chk;
    mdfr_out_t   given;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  mdfr_in_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  mdfr_out_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = REG_TIMEOUT_TICKS;
  logic [15:0] cfg_data = '0;

  // Predictor state: parser, stored reading, tick count and register copies.
  logic        rx_synced = 1'b0;
  logic [2:0]  rx_pos = POS_COUNT;
  logic [7:0]  rx_dist_hi = '0;
  logic [7:0]  rx_dist_lo = '0;
  logic [7:0]  rx_crc_lo = '0;
  logic [15:0] good_distance = '0;
  logic [15:0] tick_total = '0;
  logic [15:0] cfg_timeout = TIMEOUT_TICKS_RESET;
  logic [15:0] cfg_max_dist = MAX_DISTANCE_RESET;

  mdfr_out_t   expected_readings [$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  // When set, neither side inserts gaps or stalls.
  bit          calm = 1'b0;
  int          hold_left = 0;

  dir_row_t    dir_rows [37];

  modbus_distance_frame_receiver u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // CRC-16/Modbus over the whole frame body 01 03 02 DH DL.
  function automatic logic [15:0] frame_crc(input logic [7:0] hi, input logic [7:0] lo);
    logic [7:0]  body [5];
    logic [15:0] acc;
    body = '{ADDR_BYTE, HUNT_BYTE, COUNT_BYTE, hi, lo};
    acc = CRC_INIT;
    foreach (body[i]) begin
      acc = acc ^ {8'h00, body[i]};
      for (int k = 0; k < 8; k++) begin
        acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
      end
    end
    return acc;
  endfunction

  // Advances the predicted parser by one request; returns 1 when a reading is due.
  function automatic logic frame_parse_step(input mdfr_in_t req, output mdfr_out_t res);
    logic [15:0] frame_dist;
    logic        hit;
    hit = 1'b0;
    res = '0;
    if (req.mode == MODE_TICK) begin
      tick_total = tick_total + 16'd1;
      if (tick_total >= cfg_timeout) begin
        res = '{distance: good_distance, status: STATUS_TIMEOUT};
        hit = 1'b1;
      end
    end else if (!rx_synced) begin
      // hunting: only the function code gets us going
      if (req.rx_byte == HUNT_BYTE) begin
        rx_synced = 1'b1;
        rx_pos = POS_COUNT;
      end
    end else begin
      case (rx_pos)
        POS_COUNT: begin
          // a wrong count byte drops the sync and is not re-examined
          if (req.rx_byte != COUNT_BYTE) rx_synced = 1'b0;
          else rx_pos = POS_DIST_HIGH;
        end
        POS_DIST_HIGH: begin
          rx_dist_hi = req.rx_byte;
          rx_pos = POS_DIST_LOW;
        end
        POS_DIST_LOW: begin
          rx_dist_lo = req.rx_byte;
          rx_pos = POS_CRC_LOW;
        end
        POS_CRC_LOW: begin
          rx_crc_lo = req.rx_byte;
          rx_pos = POS_CRC_HIGH;
        end
        default: begin
          frame_dist = {rx_dist_hi, rx_dist_lo};
          if (frame_dist <= cfg_max_dist &&
              frame_crc(rx_dist_hi, rx_dist_lo) == {req.rx_byte, rx_crc_lo}) begin
            good_distance = frame_dist;
            res = '{distance: frame_dist, status: STATUS_ACCEPT};
          end else begin
            res = '{distance: good_distance, status: STATUS_REJECT};
          end
          hit = 1'b1;
        end
      endcase
    end
    // any reading restarts the hunt and the tick count
    if (hit) begin
      rx_synced = 1'b0;
      rx_pos = POS_COUNT;
      tick_total = '0;
    end
    return hit;
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Sends one request, waits for it to be taken, then books its expected reading.
  task automatic feed(input logic mode, input logic [7:0] b,
                      input row_chk_e chk = CHK_MODEL, input mdfr_out_t given = '0);
    mdfr_in_t  req;
    mdfr_out_t res;
    logic      hit;
    int        n;
    req.mode = mode;
    req.rx_byte = b;
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    hit = frame_parse_step(req, res);
    if (chk == CHK_GIVEN) expected_readings.push_back(given);
    else if (chk == CHK_MODEL && hit) expected_readings.push_back(res);
    n = pick_gap();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Sender holds off until every booked reading is out and the pipe is empty.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_TIMEOUT_TICKS) cfg_timeout = val;
    else cfg_max_dist = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Result side: random stall bursts, none while calm.
  always @(posedge clk) begin
    if (rst || calm) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      hold_left <= pick_gap();
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Reading checker: each accepted result against the oldest booked one.
  always @(posedge clk) begin
    mdfr_out_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (expected_readings.size() == 0) begin
        $display("%0t: unexpected reading, distance %0d status %0d",
                 $time, out_data.distance, out_data.status);
        mismatch_count++;
      end else begin
        exp_r = expected_readings.pop_front();
        if (out_data.distance !== exp_r.distance) begin
          $display("%0t: distance mismatch, expected %0d, actual %0d",
                   $time, exp_r.distance, out_data.distance);
          mismatch_count++;
        end
        if (out_data.status !== exp_r.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, exp_r.status, out_data.status);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: a hung handshake or a lost reading ends up here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    dir_row_t    row;
    logic [15:0] crc;
    logic [15:0] frame_dist;
    logic [15:0] t_set;
    logic [15:0] m_set;
    logic [7:0]  frame [6];
    int          sent;
    int          cut;
    int          n;
    bit          paused;

    // Directed part. Runs at reset register values until the first set row.
    dir_rows = '{
      '{ROW_TICK,        16'h0000, CHK_NONE,  '0},  // one tick is far from timeout
      '{ROW_BYTE,        16'h0003, CHK_MODEL, '0},
      '{ROW_BYTE,        16'h0003, CHK_MODEL, '0},  // not a count byte: drop, no resync
      '{ROW_BYTE,        16'h0002, CHK_NONE,  '0},  // ignored while hunting
      '{ROW_BYTE,        16'h0003, CHK_MODEL, '0},
      '{ROW_BYTE,        16'h0002, CHK_MODEL, '0},
      '{ROW_BYTE,        16'h000F, CHK_MODEL, '0},
      '{ROW_BYTE,        16'h00A0, CHK_MODEL, '0},
      '{ROW_CRC_LO,      16'h0000, CHK_MODEL, '0},
      '{ROW_CRC_HI,      16'h0000, CHK_GIVEN, '{16'd4000, STATUS_ACCEPT}},  // at the limit
      '{ROW_BYTE,        16'h0003, CHK_MODEL, '0},
      '{ROW_BYTE,        16'h0002, CHK_MODEL, '0},
      '{ROW_BYTE,        16'h000F, CHK_MODEL, '0},
      '{ROW_BYTE,        16'h00A1, CHK_MODEL, '0},
      '{ROW_CRC_LO,      16'h0000, CHK_MODEL, '0},
      '{ROW_CRC_HI,      16'h0000, CHK_GIVEN, '{16'd4000, STATUS_REJECT}},  // one past
      '{ROW_SET_MAX,     16'h0000, CHK_NONE,  '0},
      '{ROW_BYTE,        16'h0003, CHK_MODEL, '0},
      '{ROW_BYTE,        16'h0002, CHK_MODEL, '0},
      '{ROW_BYTE,        16'h0000, CHK_MODEL, '0},
      '{ROW_BYTE,        16'h0000, CHK_MODEL, '0},
      '{ROW_CRC_LO,      16'h0000, CHK_MODEL, '0},
      '{ROW_CRC_HI,      16'h0000, CHK_GIVEN, '{16'd0, STATUS_ACCEPT}},
      '{ROW_SET_MAX,     16'hFFFF, CHK_NONE,  '0},
      '{ROW_BYTE,        16'h0003, CHK_MODEL, '0},
      '{ROW_BYTE,        16'h0002, CHK_MODEL, '0},
      '{ROW_BYTE,        16'h00FF, CHK_MODEL, '0},
      '{ROW_BYTE,        16'h00FF, CHK_MODEL, '0},
      '{ROW_CRC_LO,      16'h0000, CHK_MODEL, '0},
      '{ROW_CRC_HI_BAD,  16'h0080, CHK_GIVEN, '{16'd0, STATUS_REJECT}},  // bad CRC
      '{ROW_SET_TIMEOUT, 16'h0000, CHK_NONE,  '0},
      '{ROW_TICK,        16'h0000, CHK_GIVEN, '{16'd0, STATUS_TIMEOUT}},  // zero timeout
      '{ROW_SET_TIMEOUT, 16'h0002, CHK_NONE,  '0},
      '{ROW_TICK,        16'h0000, CHK_NONE,  '0},
      '{ROW_BYTE,        16'h0003, CHK_MODEL, '0},  // bytes leave the tick count alone
      '{ROW_TICK,        16'h0000, CHK_GIVEN, '{16'd0, STATUS_TIMEOUT}},
      '{ROW_BYTE,        16'h0002, CHK_NONE,  '0}   // timeout cleared the sync
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      crc = frame_crc(rx_dist_hi, rx_dist_lo);
      case (row.kind)
        ROW_SET_TIMEOUT: begin
          drain();
          write_reg(REG_TIMEOUT_TICKS, row.arg);
        end
        ROW_SET_MAX: begin
          drain();
          write_reg(REG_MAX_DISTANCE, row.arg);
        end
        ROW_TICK:       feed(MODE_TICK, 8'($urandom), row.chk, row.given);
        ROW_CRC_LO:     feed(MODE_BYTE, crc[7:0], row.chk, row.given);
        ROW_CRC_HI:     feed(MODE_BYTE, crc[15:8], row.chk, row.given);
        ROW_CRC_HI_BAD: feed(MODE_BYTE, crc[15:8] ^ row.arg[7:0], row.chk, row.given);
        default:        feed(MODE_BYTE, row.arg[7:0], row.chk, row.given);
      endcase
    end

    // Random part: several register settings, extremes first.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      case (ph)
        0: begin
          t_set = 16'd1;
          m_set = 16'hFFFF;
        end
        1: begin
          t_set = 16'hFFFF;
          m_set = 16'h0000;
        end
        2: begin
          t_set = TIMEOUT_TICKS_RESET;
          m_set = MAX_DISTANCE_RESET;
        end
        default: begin
          t_set = 16'($urandom_range(2, 40));
          m_set = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 8000));
        end
      endcase
      write_reg(REG_TIMEOUT_TICKS, t_set);
      write_reg(REG_MAX_DISTANCE, m_set);
      sent = 0;
      paused = 1'b0;
      while (sent < REQS_PER_PHASE) begin
        // one mid-phase hold-off until the result side is fully caught up
        if (ph == 3 && sent >= REQS_PER_PHASE / 2 && !paused) begin
          drain();
          paused = 1'b1;
        end
        if ($urandom_range(0, 19) == 0) calm = !calm;
        n = $urandom_range(0, 99);
        if (n < 60) begin
          // frame, sometimes with a flipped CRC bit; distance random, near the limit or at the edges
          case ($urandom_range(0, 4))
            0: frame_dist = 16'($urandom);
            1: frame_dist = cfg_max_dist + 16'($urandom_range(0, 4)) - 16'd2;
            2: frame_dist = 16'h0000;
            3: frame_dist = 16'hFFFF;
            default: frame_dist = 16'($urandom_range(0, 4000));
          endcase
          crc = frame_crc(frame_dist[15:8], frame_dist[7:0]);
          if ($urandom_range(0, 99) < 15) crc = crc ^ (16'd1 << $urandom_range(0, 15));
          frame = '{HUNT_BYTE, COUNT_BYTE, frame_dist[15:8], frame_dist[7:0],
                    crc[7:0], crc[15:8]};
          // a broken frame stops short and leaves the parser mid-way
          cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 5) : 6;
          for (int k = 0; k < cut; k++) begin
            if ($urandom_range(0, 99) < 8) begin
              feed(MODE_TICK, 8'($urandom));
              sent++;
            end
            feed(MODE_BYTE, frame[k]);
            sent++;
          end
        end else if (n < 80) begin
          // tick run, which can reach the timeout when it is small
          cut = (cfg_timeout < 16'd40) ? int'(cfg_timeout) + 1 : 40;
          repeat ($urandom_range(1, cut)) begin
            feed(MODE_TICK, 8'($urandom));
            sent++;
          end
        end else if (n < 90) begin
          // function code followed by a wrong or random count byte
          feed(MODE_BYTE, HUNT_BYTE);
          feed(MODE_BYTE, 8'($urandom));
          sent += 2;
        end else begin
          // line noise; mostly ignored, so not counted
          repeat ($urandom_range(1, 6)) feed(MODE_BYTE, 8'($urandom));
        end
      end
      calm = 1'b0;
    end

    drain();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
